// ===== hdl/kms_pkg.sv =====
`timescale 1ns / 1ps
// kms_pkg: shared constants, state encoding and control types for the k-way merge selector.
// No dependencies; imported by every module of the block.

package kms_pkg;

   localparam int DEF_MAX_LANES = 16;   // default lane capacity
   localparam int KEY_W         = 32;   // signed key width
   localparam int LANE_FLD_W    = 4;    // lane field width on the ports
   localparam int CSR_W         = 5;    // lanes_in_use register width
   localparam int USER_W        = 5;    // lane/out_lane plus one flag bit

   localparam logic [CSR_W-1:0] LANES_RESET = 5'd16;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // sequencer -> min-scan control
   typedef struct packed {
      logic clear;   // restart the running minimum
      logic vld;     // read data of the key RAM is a scanned lane
      logic hold;    // that lane currently holds a head key
   } scan_ctl_type;

endpackage

// ===== hdl/kms_key_ram.sv =====
`timescale 1ns / 1ps
// kms_key_ram: head key store, one write port and one registered read port.
// Depends on kms_pkg for the key width.

module kms_key_ram #(
   parameter int DEPTH  = kms_pkg::DEF_MAX_LANES,
   parameter int ADDR_W = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [kms_pkg::KEY_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [kms_pkg::KEY_W-1:0] rd_data
);
   import kms_pkg::*;

   logic [KEY_W-1:0] mem_ff [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/kms_min_scan.sv =====
`timescale 1ns / 1ps
// kms_min_scan: running signed minimum over the head keys streamed out of the key RAM.
// Depends on kms_pkg (scan_ctl_type, key width).

module kms_min_scan #(
   parameter int LANE_W = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kms_pkg::scan_ctl_type     ctl,
   input  logic [LANE_W-1:0]         cmp_idx,
   input  logic [kms_pkg::KEY_W-1:0] cmp_key,
   output logic                      best_any,
   output logic [LANE_W-1:0]         best_lane,
   output logic [kms_pkg::KEY_W-1:0] best_key
);
   import kms_pkg::*;

   logic              any_ff, any_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic              take;

   // strict less-than: scan runs upward, so ties keep the lower lane
   assign take = ctl.vld && ctl.hold && (!any_ff || ($signed(cmp_key) < $signed(key_ff)));

   always_comb begin
      any_in  = any_ff;
      lane_in = lane_ff;
      key_in  = key_ff;
      if (ctl.clear) begin
         any_in = 1'b0;
      end else if (take) begin
         any_in  = 1'b1;
         lane_in = cmp_idx;
         key_in  = cmp_key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_ff <= 1'b0;
      end else begin
         any_ff <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_in;
      key_ff  <= key_in;
   end

   assign best_any  = any_ff;
   assign best_lane = lane_ff;
   assign best_key  = key_ff;

endmodule

// ===== hdl/kway_merge_selector.sv =====
`timescale 1ns / 1ps
// kway_merge_selector: k-way merge by linear scan over per-lane head keys held in a RAM.
// Steps from input accept to rsp_tvalid (n = lanes in use): check, n RAM reads
//   at one lane per cycle, drain and output load; a transaction with no result ends at the check.
// A new input is accepted only in idle, once the previous transaction is through.
// Reset: synchronous, active high; all lanes awaiting, not finished, lanes_in_use = 16.
// Depends on kms_pkg, kms_key_ram, kms_min_scan.

module kway_merge_selector #(
   parameter int MAX_LANES = kms_pkg::DEF_MAX_LANES
) (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [kms_pkg::KEY_W-1:0]  req_tdata,   // [31:0] record_key
   input  logic [kms_pkg::USER_W-1:0] req_tuser,   // [3:0] lane, [4] exhausted
   // result channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [kms_pkg::KEY_W-1:0]  rsp_tdata,   // [31:0] out_key
   output logic [kms_pkg::USER_W-1:0] rsp_tuser,   // [3:0] out_lane, [4] done_res
   // configuration
   input  logic                       csr_we,
   input  logic [kms_pkg::CSR_W-1:0]  csr_wdata    // lanes_in_use
);
   import kms_pkg::*;

   localparam int LANE_W = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
   localparam int CNT_W  = $clog2(MAX_LANES + 1);
   localparam int CMP_W  = (CNT_W > CSR_W) ? CNT_W : CSR_W;

   // ---------------- configuration ----------------
   logic [CSR_W-1:0] lanes_ff;
   logic [CMP_W-1:0] lanes_ext;
   logic [CMP_W-1:0] n_act;        // clamped lane count, 1..MAX_LANES

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff <= LANES_RESET;
      end else if (csr_we) begin
         lanes_ff <= csr_wdata;
      end
   end

   assign lanes_ext = CMP_W'(lanes_ff);

   always_comb begin
      priority if (lanes_ext == '0) begin
         n_act = CMP_W'(1);
      end else if (lanes_ext > CMP_W'(MAX_LANES)) begin
         n_act = CMP_W'(MAX_LANES);
      end else begin
         n_act = lanes_ext;
      end
   end

   // ---------------- state ----------------
   state_type         state_ff, state_in;
   logic [LANE_W-1:0] rd_idx_ff, rd_idx_in;
   logic              cmp_vld_ff;
   logic [LANE_W-1:0] cmp_idx_ff;
   // lane status as two flag vectors: neither set = awaiting
   logic [MAX_LANES-1:0] hold_ff, hold_in;
   logic [MAX_LANES-1:0] exh_ff, exh_in;
   logic                 finished_ff, finished_in;

   // output register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [KEY_W-1:0]      rsp_key_ff;
   logic [LANE_FLD_W-1:0] rsp_lane_ff;
   logic                  rsp_done_ff;

   // ---------------- input decode ----------------
   logic [LANE_FLD_W-1:0] in_lane;
   logic                  in_exh;
   logic [LANE_W-1:0]     lane_idx;
   logic                  req_acc;
   logic                  lane_ok;
   logic                  take;

   assign in_lane    = req_tuser[LANE_FLD_W-1:0];
   assign in_exh     = req_tuser[LANE_FLD_W];
   assign lane_idx   = LANE_W'(in_lane);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign lane_ok    = CMP_W'(in_lane) < n_act;
   // only an awaiting lane in use takes the transaction; all else is dropped
   assign take       = req_acc && !finished_ff && lane_ok
                       && !hold_ff[lane_idx] && !exh_ff[lane_idx];

   // any lane in use still waiting for its next key
   logic [MAX_LANES-1:0] in_use;
   logic                 any_wait;

   always_comb begin
      for (int i = 0; i < MAX_LANES; i++) begin
         in_use[i] = CMP_W'(i) < n_act;
      end
   end

   assign any_wait = |(in_use & ~hold_ff & ~exh_ff);

   // ---------------- key RAM and min scan ----------------
   logic [KEY_W-1:0]  rd_data;
   scan_ctl_type      scan_ctl;
   logic              best_any;
   logic [LANE_W-1:0] best_lane;
   logic [KEY_W-1:0]  best_key;

   kms_key_ram #(
      .DEPTH  (MAX_LANES),
      .ADDR_W (LANE_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (take && !in_exh),
      .wr_addr (lane_idx),
      .wr_data (req_tdata),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign scan_ctl.clear = (state_ff == ST_CHECK);
   assign scan_ctl.vld   = cmp_vld_ff;
   assign scan_ctl.hold  = hold_ff[cmp_idx_ff];

   kms_min_scan #(
      .LANE_W (LANE_W)
   ) u_min_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .cmp_idx   (cmp_idx_ff),
      .cmp_key   (rd_data),
      .best_any  (best_any),
      .best_lane (best_lane),
      .best_key  (best_key)
   );

   // ---------------- sequencer ----------------
   logic rsp_free;
   logic emit;
   logic scan_last;

   assign rsp_free  = !rsp_tvalid_ff || rsp_tready;
   assign emit      = (state_ff == ST_EMIT) && rsp_free;
   assign scan_last = CMP_W'(rd_idx_ff) == (n_act - CMP_W'(1));

   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // emission check is made after every transaction, dropped or not
            if (finished_ff || any_wait) begin
               state_in = ST_IDLE;
            end else begin
               state_in  = ST_SCAN;
               rd_idx_in = '0;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + LANE_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;    // last RAM word is compared this cycle
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      hold_in     = hold_ff;
      exh_in      = exh_ff;
      finished_in = finished_ff;
      if (take) begin
         if (in_exh) begin
            exh_in[lane_idx] = 1'b1;
         end else begin
            hold_in[lane_idx] = 1'b1;
         end
      end
      if (emit) begin
         if (best_any) begin
            hold_in[best_lane] = 1'b0;   // emitted lane waits for a refill
         end else begin
            finished_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_idx_ff     <= '0;
         cmp_vld_ff    <= 1'b0;
         hold_ff       <= '0;
         exh_ff        <= '0;
         finished_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_idx_ff     <= rd_idx_in;
         cmp_vld_ff    <= (state_ff == ST_SCAN);
         hold_ff       <= hold_in;
         exh_ff        <= exh_in;
         finished_ff   <= finished_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_idx_ff;
      if (emit) begin
         rsp_key_ff  <= best_any ? best_key : '0;
         rsp_lane_ff <= best_any ? LANE_FLD_W'(best_lane) : '0;
         rsp_done_ff <= !best_any;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tuser  = {rsp_done_ff, rsp_lane_ff};

`ifndef SYNTHESIS
   a_status_excl: assert property (@(posedge clock) disable iff (reset)
      (hold_ff & exh_ff) == '0)
      else $error("lane both holding and exhausted");

   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(finished_ff))
      else $error("finished flag cleared without reset");

   a_done_sets_finished: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_done_ff) |-> finished_ff)
      else $error("done transaction without finished state");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CMP_W'(rd_idx_ff) < n_act))
      else $error("scan index beyond lanes in use");

   a_emit_rearms_lane: assert property (@(posedge clock) disable iff (reset)
      (emit && best_any) |=> !hold_ff[$past(best_lane)])
      else $error("emitted lane still holding");
`endif

endmodule

// ===== test/tb_kway_merge_selector.sv =====
`timescale 1ns / 1ps
// tb_kway_merge_selector: self-checking bench for the k-way merge selector, with a scoreboard
// class that tracks per-lane heads and predicts each emitted pick. Needs kms_pkg and the RTL.

module tb_kway_merge_selector;
   import kms_pkg::*;

   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [LANE_FLD_W-1:0] lane_type;

   // per-lane bookkeeping of the merge
   typedef enum logic [1:0] {
      LANE_AWAIT,
      LANE_HOLD,
      LANE_EXH
   } lane_state_type;

   // one emitted pick: lane, key, all-runs-done flag
   typedef struct packed {
      lane_type lane;
      key_type  key;
      logic     done;
   } merge_pick_type;

   // one request transaction
   typedef struct packed {
      lane_type lane;
      key_type  key;
      logic     ex;
   } req_item_type;

   localparam key_type KEY_MAX    = 32'h7fff_ffff;
   localparam key_type KEY_MIN    = 32'h8000_0000;
   // lanes 0 and 1 are never exhausted before the closing drain, so the block
   // cannot reach its finished state early (it only leaves it on reset)
   localparam int      KEPT_LANES = 2;
   localparam int      NUM_SEGS   = 9;
   localparam int      SEG_ITEMS  = 115;

   // lane count per segment: below, at and above the legal range
   localparam logic [CSR_W-1:0] LANE_PLAN [NUM_SEGS] =
      '{5'd1, 5'd0, 5'd31, 5'd3, 5'd2, 5'd17, 5'd9, 5'd5, 5'd16};

   // ------------------------------------------------------------------
   // scoreboard: mirrors head keys and lane states, queues predicted picks
   // ------------------------------------------------------------------
   class merge_scoreboard;
      logic signed [KEY_W-1:0] head_key [DEF_MAX_LANES];
      lane_state_type          status   [DEF_MAX_LANES];
      bit                      finished;
      logic [CSR_W-1:0]        lanes_cfg;
      merge_pick_type          picks_due [$];
      int                      errors;

      function new();
         for (int i = 0; i < DEF_MAX_LANES; i++) begin
            head_key[i] = '0;
            status[i]   = LANE_AWAIT;
         end
         finished  = 1'b0;
         lanes_cfg = LANES_RESET;
         errors    = 0;
      endfunction

      // register value clamped to 1..MAX_LANES
      function int active_count();
         int n;
         n = int'(lanes_cfg);
         if (n < 1) n = 1;
         if (n > DEF_MAX_LANES) n = DEF_MAX_LANES;
         return n;
      endfunction

      function bit lane_waiting(int l);
         return !finished && l < active_count() && status[l] == LANE_AWAIT;
      endfunction

      function int pending();
         return picks_due.size();
      endfunction

      task log_mismatch(string what);
         if (errors < 100) $display("mismatch: %s", what);
         errors++;
      endtask

      // accepted request: update the lane, then emit once no lane in use waits.
      // Returns 1 when the transaction changed state or caused a pick.
      function bit absorb_input(lane_type lane, key_type key, logic ex);
         int             n;
         int             best;
         bit             moved;
         merge_pick_type pick;
         moved = 1'b0;
         if (finished) return 1'b0;
         n = active_count();
         if (int'(lane) < n && status[lane] == LANE_AWAIT) begin
            status[lane] = ex ? LANE_EXH : LANE_HOLD;
            if (!ex) head_key[lane] = key;
            moved = 1'b1;
         end
         for (int i = 0; i < n; i++)
            if (status[i] == LANE_AWAIT) return moved;
         // strict less-than keeps the lowest lane on ties
         best = -1;
         for (int i = 0; i < n; i++)
            if (status[i] == LANE_HOLD && (best < 0 || head_key[i] < head_key[best]))
               best = i;
         if (best < 0) begin
            finished = 1'b1;
            pick = '{lane: '0, key: '0, done: 1'b1};
         end else begin
            status[best] = LANE_AWAIT;
            pick = '{lane: lane_type'(best), key: head_key[best], done: 1'b0};
         end
         picks_due.push_back(pick);
         return 1'b1;
      endfunction

      task check_pick(lane_type lane, key_type key, logic done);
         merge_pick_type want;
         if (picks_due.size() == 0) begin
            log_mismatch($sformatf("unexpected pick lane %0d key %0d done %0b",
                                   lane, $signed(key), done));
            return;
         end
         want = picks_due.pop_front();
         if (lane !== want.lane)
            log_mismatch($sformatf("out_lane %0d, predicted %0d", lane, want.lane));
         if (key !== want.key)
            log_mismatch($sformatf("out_key %0d, predicted %0d", $signed(key),
                                   $signed(want.key)));
         if (done !== want.done)
            log_mismatch($sformatf("done_res %0b, predicted %0b", done, want.done));
      endtask
   endclass

   // ------------------------------------------------------------------
   // clock, reset, DUT
   // ------------------------------------------------------------------
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [KEY_W-1:0]     req_tdata  = '0;   // [31:0] record_key
   logic [USER_W-1:0]    req_tuser  = '0;   // [3:0] lane, [4] exhausted
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [KEY_W-1:0]     rsp_tdata;         // [31:0] out_key
   logic [USER_W-1:0]    rsp_tuser;         // [3:0] out_lane, [4] done_res
   logic                 csr_we     = 1'b0;
   logic [CSR_W-1:0]     csr_wdata  = '0;   // lanes_in_use

   merge_scoreboard sb = new();

   // idle percentages for the current phase
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   kway_merge_selector #(.MAX_LANES(DEF_MAX_LANES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   // result monitor: every accepted pick goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_pick(rsp_tuser[LANE_FLD_W-1:0], rsp_tdata, rsp_tuser[LANE_FLD_W]);
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // extremes, a narrow band around zero for ties, otherwise anything
   function automatic key_type draw_key();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (roll < 10) begin
         case ($urandom_range(0, 3))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      if (roll < 40) return key_type'(int'($urandom_range(0, 16)) - 8);
      return key_type'($urandom());
   endfunction

   // mostly a refill of a waiting lane; the rest is noise to any lane.
   // Exhausting a lane is rare and never hits the kept lanes.
   function automatic req_item_type draw_item();
      req_item_type it;
      int           waiting [$];
      int           n;
      n = sb.active_count();
      for (int i = 0; i < n; i++)
         if (sb.lane_waiting(i)) waiting.push_back(i);
      it.key = draw_key();
      it.ex  = 1'b0;
      if (waiting.size() != 0 && $urandom_range(0, 99) < 80) begin
         it.lane = lane_type'(waiting[$urandom_range(0, waiting.size() - 1)]);
         if (int'(it.lane) >= KEPT_LANES && $urandom_range(0, 99) == 0) it.ex = 1'b1;
      end else begin
         it.lane = lane_type'($urandom_range(0, DEF_MAX_LANES - 1));
         it.ex   = 1'($urandom_range(0, 1));
         if (it.ex && (int'(it.lane) < KEPT_LANES || $urandom_range(0, 7) != 0) &&
             sb.lane_waiting(int'(it.lane)))
            it.ex = 1'b0;
      end
      return it;
   endfunction

   // one request transaction. Valid is only dropped for an idle cycle, so it
   // never gets two assignments in the acceptance step.
   task automatic send_item(req_item_type it, output bit took);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it.key;
      req_tuser  <= {it.ex, it.lane};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      took = sb.absorb_input(it.lane, it.key, it.ex);
   endtask

   task automatic send_fields(int lane, key_type key, logic ex);
      req_item_type it;
      bit           took;
      it = '{lane: lane_type'(lane), key: key, ex: ex};
      send_item(it, took);
   endtask

   // register write only with the block idle: all picks in, plus the
   // no-result latency for a trailing transaction that emitted nothing
   task automatic write_lane_count(logic [CSR_W-1:0] value);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we       <= 1'b0;
      sb.lanes_cfg  = value;
   endtask

   // fill all sixteen lanes at reset config, then walk through ties,
   // extremes, ignored inputs and one early exhaustion
   task automatic run_directed();
      key_type k;
      for (int i = 0; i < DEF_MAX_LANES; i++) begin
         case (i)
            0:       k = KEY_MAX;
            1, 2:    k = 5;
            3:       k = KEY_MIN;
            4:       k = '0;
            5:       k = '1;
            default: k = key_type'(1000 + i);
         endcase
         send_fields(i, k, 1'b0);          // last fill emits lane 3 (most negative)
      end
      send_fields(7, 123, 1'b0);           // lane holding: dropped
      send_fields(1, '0, 1'b1);            // exhaust on a holding lane: dropped
      send_fields(3, KEY_MIN, 1'b0);       // same extreme again, lane 3 again
      send_fields(3, 7, 1'b0);             // -1 on lane 5 wins
      send_fields(5, 5, 1'b0);             // zero on lane 4
      send_fields(4, 5, 1'b0);             // four-way tie on 5, lowest lane wins
      send_fields(1, 6, 1'b0);
      send_fields(2, '0, 1'b1);            // waiting lane exhausted
      send_fields(4, KEY_MAX, 1'b0);
      send_fields(15, '0, 1'b0);           // top lane index, holding: dropped
      send_fields(5, KEY_MAX, 1'b0);
   endtask

   task automatic run_random(int target);
      req_item_type it;
      bit           took;
      int           taken;
      taken = 0;
      while (taken < target) begin
         it = draw_item();
         send_item(it, took);
         if (took) taken++;
      end
   endtask

   // exhaust every lane in use until the done pick, then show that the
   // finished block drops everything
   task automatic run_closing();
      req_item_type it;
      bit           took;
      int           lane_pick;
      while (!sb.finished) begin
         lane_pick = -1;
         for (int i = DEF_MAX_LANES - 1; i >= 0; i--)
            if (sb.lane_waiting(i)) lane_pick = i;
         it.key = draw_key();
         if (lane_pick >= 0) begin
            it.lane = lane_type'(lane_pick);
            it.ex   = 1'b1;
         end else begin
            it.lane = lane_type'($urandom_range(0, DEF_MAX_LANES - 1));
            it.ex   = 1'b0;
         end
         send_item(it, took);
      end
      repeat (4) begin
         it.lane = lane_type'($urandom_range(0, DEF_MAX_LANES - 1));
         it.key  = draw_key();
         it.ex   = 1'($urandom_range(0, 1));
         send_item(it, took);
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles lightly, receiver stalls heavily
      src_idle_pct   = 36;
      sink_stall_pct = 69;
      run_directed();

      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         if (seg == 3) begin                 // roles swapped
            src_idle_pct   = 69;
            sink_stall_pct = 36;
         end else if (seg == 6) begin        // full rate both sides
            src_idle_pct   = 0;
            sink_stall_pct = 0;
         end
         write_lane_count(LANE_PLAN[seg]);
         run_random(SEG_ITEMS);
      end
      run_closing();

      // drain: wait for the outstanding picks, then watch for strays
      req_tvalid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (sb.pending() != 0)
         sb.log_mismatch($sformatf("%0d predicted picks never arrived", sb.pending()));

      if (sb.errors == 0) begin
         $display("tb_kway_merge_selector: clean");
      end else begin
         $display("tb_kway_merge_selector: errors");
      end
      $finish;
   end

   // watchdog: leaves ample margin over all segments plus worst-case idling on both
   // sides
   initial begin
      #2_000_000;
      $display("tb_kway_merge_selector: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/kms_pkg.sv
hdl/kms_key_ram.sv
hdl/kms_min_scan.sv
hdl/kway_merge_selector.sv
test/tb_kway_merge_selector.sv
